>>> src/ipac_pkg.sv
// Shared types, constants and helper functions for the IP address classifier.
`default_nettype none

package ipac_pkg;

   typedef enum logic [1:0] {
      FAM_NONE = 2'd0,
      FAM_V4   = 2'd1,
      FAM_V6   = 2'd2,
      FAM_RSVD = 2'd3
   } family_type;

   localparam logic [5:0] PREC_NONE    = 6'd0;
   localparam logic [5:0] PREC_LEGACY  = 6'd1;
   localparam logic [5:0] PREC_TEREDO  = 6'd10;
   localparam logic [5:0] PREC_6TO4    = 6'd20;
   localparam logic [5:0] PREC_V4      = 6'd30;
   localparam logic [5:0] PREC_V6      = 6'd40;
   localparam logic [5:0] PREC_ULA     = 6'd50;
   localparam logic [5:0] PREC_LOOP    = 6'd60;

   localparam int KIND_SITE   = 0;
   localparam int KIND_ULA    = 1;
   localparam int KIND_TEREDO = 2;
   localparam int KIND_6TO4   = 3;
   localparam int KIND_MAPPED = 4;
   localparam int KIND_COMPAT = 5;
   localparam int KIND_6BONE  = 6;
   localparam int KIND_MAC    = 7;

   localparam logic [31:0] WORD_ONES     = 32'hFFFF_FFFF;
   localparam logic [7:0]  V4_NET10      = 8'd10;
   localparam logic [11:0] V4_NET172     = 12'hAC1;
   localparam logic [15:0] V4_NET192     = 16'hC0A8;
   localparam logic [15:0] V4_LINK_LOCAL = 16'hA9FE;
   localparam logic [9:0]  V4_SHARED     = 10'h191;
   localparam logic [7:0]  V4_LOOPBACK   = 8'd127;
   localparam logic [31:0] V6_TEREDO     = 32'h2001_0000;
   localparam logic [15:0] V6_6TO4       = 16'h2002;
   localparam logic [15:0] V6_6BONE      = 16'h3FFE;
   localparam logic [31:0] V6_MAPPED_TAG = 32'h0000_FFFF;
   localparam logic [7:0]  V4_WIDTH      = 8'd32;
   localparam logic [7:0]  V6_WIDTH      = 8'd128;

   typedef struct packed {
      family_type  family;
      logic [63:0] address_high;
      logic [63:0] address_low;
      logic [7:0]  prefix_length;
   } req_type;

   typedef struct packed {
      logic [5:0]  precedence;
      logic        is_private;
      logic        is_loopback;
      logic        is_link_local;
      logic        is_any;
      logic [7:0]  ipv6_kind;
      logic [63:0] truncated_high;
      logic [63:0] truncated_low;
      logic [7:0]  mask_bit_count;
      logic [31:0] word_hash;
   } rsp_type;

   // 32 minus trailing zeros, zero for a zero word
   function automatic logic [5:0] word_span(input logic [31:0] w);
      logic [31:0] x;
      logic [4:0]  tz;
      x  = w;
      tz = '0;
      if (x[15:0] == 16'd0) begin
         tz[4] = 1'b1;
         x     = {16'd0, x[31:16]};
      end
      if (x[7:0] == 8'd0) begin
         tz[3] = 1'b1;
         x     = {8'd0, x[31:8]};
      end
      if (x[3:0] == 4'd0) begin
         tz[2] = 1'b1;
         x     = {4'd0, x[31:4]};
      end
      if (x[1:0] == 2'd0) begin
         tz[1] = 1'b1;
         x     = {2'd0, x[31:2]};
      end
      if (x[0] == 1'b0) begin
         tz[0] = 1'b1;
      end
      if (w == 32'd0) begin
         return 6'd0;
      end
      return 6'd32 - {1'b0, tz};
   endfunction

endpackage

`default_nettype wire

>>> src/ipac_classify.sv
// Combinational classification, truncation, mask count and hash of one address.
`default_nettype none

module ipac_classify (
   input  var ipac_pkg::req_type req,
   output var ipac_pkg::rsp_type rsp
);

   logic [31:0]  a4;
   logic [31:0]  w0, w1, w2, w3;
   logic [7:0]   b0, b1;
   logic [15:0]  first16;
   logic         hi_zero;
   logic         v4_pnet, v4_shared, v4_loop, v4_ll;
   logic         v6_loop, v6_ll, site, ula, ter, six, mapped, compat, bone, mac;
   logic [31:0]  m4;
   logic [127:0] m6;
   logic [31:0]  pick_word;
   logic [7:0]   pick_base;
   logic [7:0]   v6_mbits;

   assign a4      = req.address_low[31:0];
   assign w0      = req.address_high[63:32];
   assign w1      = req.address_high[31:0];
   assign w2      = req.address_low[63:32];
   assign w3      = req.address_low[31:0];
   assign b0      = req.address_high[63:56];
   assign b1      = req.address_high[55:48];
   assign first16 = req.address_high[63:48];
   assign hi_zero = (req.address_high == 64'd0);

   assign v4_pnet   = (a4[31:24] == ipac_pkg::V4_NET10) || (a4[31:20] == ipac_pkg::V4_NET172) ||
                      (a4[31:16] == ipac_pkg::V4_NET192);
   assign v4_shared = (a4[31:22] == ipac_pkg::V4_SHARED);
   assign v4_loop   = (a4[31:24] == ipac_pkg::V4_LOOPBACK);
   assign v4_ll     = (a4[31:16] == ipac_pkg::V4_LINK_LOCAL);

   assign v6_loop = hi_zero && (req.address_low == 64'd1);
   assign v6_ll   = (b0 == 8'hFE) && (b1[7:6] == 2'b10);
   assign site    = (b0 == 8'hFE) && (b1[7:6] == 2'b11);
   assign ula     = (b0[7:1] == 7'h7E);
   assign ter     = (w0 == ipac_pkg::V6_TEREDO);
   assign six     = (first16 == ipac_pkg::V6_6TO4);
   assign mapped  = hi_zero && (w2 == ipac_pkg::V6_MAPPED_TAG);
   assign compat  = hi_zero && (w2 == 32'd0);
   assign bone    = (first16 == ipac_pkg::V6_6BONE);
   assign mac     = req.address_low[57] && (req.address_low[39:32] == 8'hFF) &&
                    (req.address_low[31:24] == 8'hFE);

   assign m4 = (req.prefix_length >= ipac_pkg::V4_WIDTH) ? ipac_pkg::WORD_ONES :
               ~(ipac_pkg::WORD_ONES >> req.prefix_length[4:0]);
   assign m6 = (req.prefix_length >= ipac_pkg::V6_WIDTH) ? {128{1'b1}} :
               ~({128{1'b1}} >> req.prefix_length);

   always_comb begin
      if (w0 != ipac_pkg::WORD_ONES) begin
         pick_word = w0;
         pick_base = 8'd0;
      end else if (w1 != ipac_pkg::WORD_ONES) begin
         pick_word = w1;
         pick_base = 8'd32;
      end else if (w2 != ipac_pkg::WORD_ONES) begin
         pick_word = w2;
         pick_base = 8'd64;
      end else if (w3 != ipac_pkg::WORD_ONES) begin
         pick_word = w3;
         pick_base = 8'd96;
      end else begin
         pick_word = 32'd0;
         pick_base = 8'd128;
      end
   end

   assign v6_mbits = pick_base + {2'b00, ipac_pkg::word_span(pick_word)};

   always_comb begin
      rsp = '0;
      case (req.family)
         ipac_pkg::FAM_V4: begin
            rsp.precedence     = ipac_pkg::PREC_V4;
            rsp.is_loopback    = v4_loop;
            rsp.is_link_local  = v4_ll;
            rsp.is_private     = v4_ll | v4_loop | v4_pnet | v4_shared;
            rsp.is_any         = (a4 == 32'd0);
            rsp.truncated_low  = {32'd0, a4 & m4};
            rsp.mask_bit_count = {2'b00, ipac_pkg::word_span(a4)};
            rsp.word_hash      = a4;
         end
         ipac_pkg::FAM_V6: begin
            if (v6_loop) begin
               rsp.precedence = ipac_pkg::PREC_LOOP;
            end else if (ula) begin
               rsp.precedence = ipac_pkg::PREC_ULA;
            end else if (mapped) begin
               rsp.precedence = ipac_pkg::PREC_V4;
            end else if (six) begin
               rsp.precedence = ipac_pkg::PREC_6TO4;
            end else if (ter) begin
               rsp.precedence = ipac_pkg::PREC_TEREDO;
            end else if (compat || site || bone) begin
               rsp.precedence = ipac_pkg::PREC_LEGACY;
            end else begin
               rsp.precedence = ipac_pkg::PREC_V6;
            end
            rsp.is_loopback   = v6_loop;
            rsp.is_link_local = v6_ll;
            rsp.is_private    = v6_ll | v6_loop | (b0 == 8'hFD);
            rsp.is_any        = hi_zero && ((req.address_low == 64'd0) ||
                                (req.address_low == {ipac_pkg::V6_MAPPED_TAG, 32'd0}));
            rsp.ipv6_kind[ipac_pkg::KIND_SITE]   = site;
            rsp.ipv6_kind[ipac_pkg::KIND_ULA]    = ula;
            rsp.ipv6_kind[ipac_pkg::KIND_TEREDO] = ter;
            rsp.ipv6_kind[ipac_pkg::KIND_6TO4]   = six;
            rsp.ipv6_kind[ipac_pkg::KIND_MAPPED] = mapped;
            rsp.ipv6_kind[ipac_pkg::KIND_COMPAT] = compat;
            rsp.ipv6_kind[ipac_pkg::KIND_6BONE]  = bone;
            rsp.ipv6_kind[ipac_pkg::KIND_MAC]    = mac;
            rsp.truncated_high = req.address_high & m6[127:64];
            rsp.truncated_low  = req.address_low & m6[63:0];
            rsp.mask_bit_count = v6_mbits;
            rsp.word_hash      = w0 ^ w1 ^ w2 ^ w3;
         end
         default: begin
            rsp = '0;
         end
      endcase
   end

endmodule

`default_nettype wire

>>> src/ip_address_classifier.sv
// Top level of the IP address classifier: input register, classifier, result register.
//
//   channel  prefix  direction  content
//   request  req_    in         family, 128 address bits, prefix length
//   response rsp_    out        precedence, flags, kind, truncated address, count, hash
//
// One beat in per cycle unless the result side stalls; a response leaves from the result register.
// The input register and the result register form a two-entry pipeline that stalls from the
// result side; req_ready is low only during reset or when both stages hold a beat and
// rsp_ready is low.
// Reset clears both stage valids; the payload registers are not reset.
`default_nettype none

module ip_address_classifier (
   input  var logic        clock,
   input  var logic        reset,
   input  var logic        req_valid,
   output var logic        req_ready,
   input  var logic [1:0]  req_family,
   input  var logic [63:0] req_address_high,
   input  var logic [63:0] req_address_low,
   input  var logic [7:0]  req_prefix_length,
   output var logic        rsp_valid,
   input  var logic        rsp_ready,
   output var logic [5:0]  rsp_precedence,
   output var logic        rsp_is_private,
   output var logic        rsp_is_loopback,
   output var logic        rsp_is_link_local,
   output var logic        rsp_is_any,
   output var logic [7:0]  rsp_ipv6_kind,
   output var logic [63:0] rsp_truncated_high,
   output var logic [63:0] rsp_truncated_low,
   output var logic [7:0]  rsp_mask_bit_count,
   output var logic [31:0] rsp_word_hash
);

   ipac_pkg::req_type req_ff, req_in;
   ipac_pkg::rsp_type rsp_ff, rsp_in, rsp_comb;
   logic              s1_valid_ff, s1_valid_in;
   logic              s2_valid_ff, s2_valid_in;
   logic              s1_ready, s2_ready;

   assign s2_ready  = !s2_valid_ff || rsp_ready;
   assign s1_ready  = !s1_valid_ff || s2_ready;
   assign req_ready = s1_ready && !reset;

   ipac_classify u_classify (
      .req (req_ff),
      .rsp (rsp_comb)
   );

   always_comb begin
      req_in      = req_ff;
      s1_valid_in = s1_valid_ff;
      if (s1_ready) begin
         s1_valid_in = req_valid;
         if (req_valid) begin
            req_in = '{family:        ipac_pkg::family_type'(req_family),
                       address_high:  req_address_high,
                       address_low:   req_address_low,
                       prefix_length: req_prefix_length};
         end
      end
   end

   always_comb begin
      rsp_in      = rsp_ff;
      s2_valid_in = s2_valid_ff;
      if (s2_ready) begin
         s2_valid_in = s1_valid_ff;
         if (s1_valid_ff) begin
            rsp_in = rsp_comb;
         end
      end
   end

   always_ff @(posedge clock) begin
      req_ff <= req_in;
      rsp_ff <= rsp_in;
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
      end
   end

   assign rsp_valid          = s2_valid_ff;
   assign rsp_precedence     = rsp_ff.precedence;
   assign rsp_is_private     = rsp_ff.is_private;
   assign rsp_is_loopback    = rsp_ff.is_loopback;
   assign rsp_is_link_local  = rsp_ff.is_link_local;
   assign rsp_is_any         = rsp_ff.is_any;
   assign rsp_ipv6_kind      = rsp_ff.ipv6_kind;
   assign rsp_truncated_high = rsp_ff.truncated_high;
   assign rsp_truncated_low  = rsp_ff.truncated_low;
   assign rsp_mask_bit_count = rsp_ff.mask_bit_count;
   assign rsp_word_hash      = rsp_ff.word_hash;

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !s1_valid_ff && !s2_valid_ff)
      else $error("pipeline not empty after reset");

   a_accept_loads: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> s1_valid_ff)
      else $error("accepted beat not held in input stage");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !s2_ready |=> s1_valid_ff && $stable(req_ff))
      else $error("input stage lost a beat during stall");

   a_loop_private: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_is_loopback || rsp_is_link_local) |-> rsp_is_private)
      else $error("loopback or link-local beat not flagged private");

   a_prec_legal: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_precedence == ipac_pkg::PREC_NONE) ||
                    (rsp_precedence == ipac_pkg::PREC_LEGACY) ||
                    (rsp_precedence == ipac_pkg::PREC_TEREDO) ||
                    (rsp_precedence == ipac_pkg::PREC_6TO4) ||
                    (rsp_precedence == ipac_pkg::PREC_V4) ||
                    (rsp_precedence == ipac_pkg::PREC_V6) ||
                    (rsp_precedence == ipac_pkg::PREC_ULA) ||
                    (rsp_precedence == ipac_pkg::PREC_LOOP))
      else $error("illegal precedence value");

endmodule

`default_nettype wire

>>> tb/sv/tb_ip_address_classifier.sv
// Self-checking testbench for ip_address_classifier: directed and random addresses under backpressure.
`default_nettype none

module tb_ip_address_classifier;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int WATCHDOG_LIMIT = 1000;
   localparam int HOLD_CYCLES    = 60;
   localparam int RANDOM_ITEMS   = 160;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [1:0]  req_family = ipac_pkg::FAM_NONE;
   logic [63:0] req_address_high = '0;
   logic [63:0] req_address_low = '0;
   logic [7:0]  req_prefix_length = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [5:0]  rsp_precedence;
   logic        rsp_is_private;
   logic        rsp_is_loopback;
   logic        rsp_is_link_local;
   logic        rsp_is_any;
   logic [7:0]  rsp_ipv6_kind;
   logic [63:0] rsp_truncated_high;
   logic [63:0] rsp_truncated_low;
   logic [7:0]  rsp_mask_bit_count;
   logic [31:0] rsp_word_hash;

   ipac_pkg::rsp_type predicted_classes[$];
   int      mismatches = 0;
   int      quiet_cycles = 0;
   int      send_idle_pct = 0;
   int      stall_pct = 0;
   bit      hold_pending = 1'b0;

   ip_address_classifier uut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_family         (req_family),
      .req_address_high   (req_address_high),
      .req_address_low    (req_address_low),
      .req_prefix_length  (req_prefix_length),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_precedence     (rsp_precedence),
      .rsp_is_private     (rsp_is_private),
      .rsp_is_loopback    (rsp_is_loopback),
      .rsp_is_link_local  (rsp_is_link_local),
      .rsp_is_any         (rsp_is_any),
      .rsp_ipv6_kind      (rsp_ipv6_kind),
      .rsp_truncated_high (rsp_truncated_high),
      .rsp_truncated_low  (rsp_truncated_low),
      .rsp_mask_bit_count (rsp_mask_bit_count),
      .rsp_word_hash      (rsp_word_hash)
   );

   always #1 clock = ~clock;

   function automatic logic [7:0] low_span(input logic [31:0] w);
      if (w == 32'd0) begin
         return 8'd0;
      end
      for (int n = 0; n < 32; n++) begin
         if (w[n]) begin
            return 8'(32 - n);
         end
      end
      return 8'd0;
   endfunction

   function automatic ipac_pkg::rsp_type classify_address(input ipac_pkg::family_type fam,
                                                          input logic [63:0] hi,
                                                          input logic [63:0] lo,
                                                          input logic [7:0] len);
      ipac_pkg::rsp_type r;
      logic [31:0] a;
      logic [31:0] w [4];
      logic [7:0]  b0, b1;
      logic [15:0] top16;
      logic [127:0] keep;
      logic        site, ula, ter, six, mapped, compat, bone, mac;
      int          i;
      r = '0;
      if (fam == ipac_pkg::FAM_V4) begin
         a = lo[31:0];
         r.precedence    = ipac_pkg::PREC_V4;
         r.is_loopback   = (a[31:24] == 8'd127);
         r.is_link_local = (a[31:16] == 16'hA9FE);
         r.is_private    = r.is_loopback | r.is_link_local | (a[31:24] == 8'd10) |
                           (a[31:20] == 12'hAC1) | (a[31:16] == 16'hC0A8) |
                           (a[31:22] == 10'h191);
         r.is_any        = (a == 32'd0);
         r.truncated_low = (len >= 8'd32) ? {32'd0, a} : {32'd0, a & ~(32'hFFFF_FFFF >> len)};
         r.mask_bit_count = low_span(a);
         r.word_hash     = a;
      end else if (fam == ipac_pkg::FAM_V6) begin
         w[0]   = hi[63:32];
         w[1]   = hi[31:0];
         w[2]   = lo[63:32];
         w[3]   = lo[31:0];
         b0     = hi[63:56];
         b1     = hi[55:48];
         top16  = hi[63:48];
         site   = (b0 == 8'hFE) && (b1[7:6] == 2'b11);
         ula    = (b0[7:1] == 7'b1111110);
         ter    = (w[0] == 32'h2001_0000);
         six    = (top16 == 16'h2002);
         mapped = (hi == 64'd0) && (w[2] == 32'h0000_FFFF);
         compat = (hi == 64'd0) && (w[2] == 32'd0);
         bone   = (top16 == 16'h3FFE);
         mac    = lo[57] && (lo[39:32] == 8'hFF) && (lo[31:24] == 8'hFE);
         r.ipv6_kind[ipac_pkg::KIND_SITE]   = site;
         r.ipv6_kind[ipac_pkg::KIND_ULA]    = ula;
         r.ipv6_kind[ipac_pkg::KIND_TEREDO] = ter;
         r.ipv6_kind[ipac_pkg::KIND_6TO4]   = six;
         r.ipv6_kind[ipac_pkg::KIND_MAPPED] = mapped;
         r.ipv6_kind[ipac_pkg::KIND_COMPAT] = compat;
         r.ipv6_kind[ipac_pkg::KIND_6BONE]  = bone;
         r.ipv6_kind[ipac_pkg::KIND_MAC]    = mac;
         r.is_loopback   = (hi == 64'd0) && (lo == 64'd1);
         r.is_link_local = (b0 == 8'hFE) && (b1[7:6] == 2'b10);
         r.is_private    = r.is_loopback | r.is_link_local | (b0 == 8'hFD);
         r.is_any        = (hi == 64'd0) && ((lo == 64'd0) || (lo == 64'h0000_FFFF_0000_0000));
         if (r.is_loopback) r.precedence = ipac_pkg::PREC_LOOP;
         else if (ula) r.precedence = ipac_pkg::PREC_ULA;
         else if (mapped) r.precedence = ipac_pkg::PREC_V4;
         else if (six) r.precedence = ipac_pkg::PREC_6TO4;
         else if (ter) r.precedence = ipac_pkg::PREC_TEREDO;
         else if (compat || site || bone) r.precedence = ipac_pkg::PREC_LEGACY;
         else r.precedence = ipac_pkg::PREC_V6;
         keep = (len >= 8'd128) ? '1 : ~({128{1'b1}} >> len);
         r.truncated_high = hi & keep[127:64];
         r.truncated_low  = lo & keep[63:0];
         i = 0;
         while (i < 4 && w[i] == 32'hFFFF_FFFF) begin
            i++;
         end
         r.mask_bit_count = 8'(i * 32) + ((i < 4) ? low_span(w[i]) : 8'd0);
         r.word_hash      = w[0] ^ w[1] ^ w[2] ^ w[3];
      end
      return r;
   endfunction

   task automatic send_address(input ipac_pkg::family_type fam, input logic [63:0] hi,
                               input logic [63:0] lo, input logic [7:0] len);
      int gap;
      gap = ($urandom_range(99) < send_idle_pct) ? $urandom_range(1, 5) : 0;
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid         <= 1'b1;
      req_family        <= fam;
      req_address_high  <= hi;
      req_address_low   <= lo;
      req_prefix_length <= len;
      do @(posedge clock); while (!req_ready);
      predicted_classes.push_back(classify_address(fam, hi, lo, len));
      @(negedge clock);
   endtask

   task automatic stop_sending();
      req_valid <= 1'b0;
      @(negedge clock);
   endtask

   task automatic send_random_address();
      logic [127:0] addr;
      logic [7:0]   len;
      ipac_pkg::family_type fam;
      int           pick;
      addr = {$urandom, $urandom, $urandom, $urandom};
      pick = $urandom_range(0, 9);
      fam  = ipac_pkg::FAM_V6;
      if (pick == 0) begin
         fam = ($urandom_range(0, 1) != 0) ? ipac_pkg::FAM_NONE : ipac_pkg::FAM_RSVD;
      end else if (pick <= 3) begin
         fam = ipac_pkg::FAM_V4;
         case ($urandom_range(0, 8))
            0: addr[31:24] = 8'd10;
            1: addr[31:20] = 12'hAC1;
            2: addr[31:16] = 16'hC0A8;
            3: addr[31:16] = 16'hA9FE;
            4: addr[31:22] = 10'h191;
            5: addr[31:24] = 8'd127;
            6: addr[31:0]  = 32'd0;
            7: addr[31:0]  = ~(32'hFFFF_FFFF >> $urandom_range(0, 32));
            default: ;
         endcase
      end else if (pick <= 7) begin
         case ($urandom_range(0, 12))
            0: addr[127:118] = 10'b1111111010;
            1: addr[127:118] = 10'b1111111011;
            2: addr[127:121] = 7'b1111110;
            3: addr[127:96]  = 32'h2001_0000;
            4: addr[127:112] = 16'h2002;
            5: addr[127:112] = 16'h3FFE;
            6: addr[127:32]  = {64'd0, 32'h0000_FFFF};
            7: addr[127:32]  = '0;
            8: addr = 128'd1;
            9: addr = ($urandom_range(0, 1) != 0) ? 128'd0 : {64'd0, 64'h0000_FFFF_0000_0000};
            10: begin
               addr[57]    = 1'b1;
               addr[39:24] = 16'hFFFE;
            end
            11: addr = ~({128{1'b1}} >> $urandom_range(0, 128));
            default: ;
         endcase
      end else if (pick == 8) begin
         addr = ~({128{1'b1}} >> $urandom_range(0, 128));
         if ($urandom_range(0, 1) != 0) begin
            addr[$urandom_range(0, 127)] = 1'b1;
         end
         fam = ($urandom_range(0, 2) == 0) ? ipac_pkg::FAM_V4 : ipac_pkg::FAM_V6;
         if (fam == ipac_pkg::FAM_V4) begin
            addr[31:0] = addr[127:96];
         end
      end
      case ($urandom_range(0, 9))
         0: len = 8'd0;
         1: len = 8'd128;
         2: len = 8'($urandom_range(129, 255));
         3: len = 8'd32;
         4: len = 8'($urandom_range(0, 32));
         default: len = 8'($urandom_range(0, 128));
      endcase
      send_address(fam, addr[127:64], addr[63:0], len);
   endtask

   task automatic run_random_phase(input int idle_pct, input int stall, input int count);
      send_idle_pct = idle_pct;
      stall_pct     = stall;
      repeat (count) send_random_address();
   endtask

   task automatic test_directed();
      send_address(ipac_pkg::FAM_NONE, '1, '1, 8'd128);
      send_address(ipac_pkg::FAM_RSVD, 64'h0123_4567_89AB_CDEF, 64'hFEDC_BA98_7654_3210,
                   8'd255);
      send_address(ipac_pkg::FAM_V4, 64'd0, 64'd0, 8'd0);
      send_address(ipac_pkg::FAM_V4, '1, '1, 8'd32);
      send_address(ipac_pkg::FAM_V4, 64'd0, 64'h0000_0000_0A01_0203, 8'd8);
      send_address(ipac_pkg::FAM_V4, 64'd0, 64'h0000_0000_AC10_0001, 8'd255);
      send_address(ipac_pkg::FAM_V4, 64'd0, 64'h0000_0000_AC1F_FFFF, 8'd12);
      send_address(ipac_pkg::FAM_V4, 64'd0, 64'h0000_0000_AC20_0001, 8'd31);
      send_address(ipac_pkg::FAM_V4, 64'd0, 64'h0000_0000_C0A8_0101, 8'd16);
      send_address(ipac_pkg::FAM_V4, 64'd0, 64'h0000_0000_A9FE_0005, 8'd1);
      send_address(ipac_pkg::FAM_V4, 64'd0, 64'h0000_0000_6440_0000, 8'd10);
      send_address(ipac_pkg::FAM_V4, 64'hDEAD_BEEF_0BAD_F00D, 64'h5555_AAAA_7F00_0001, 8'd33);
      send_address(ipac_pkg::FAM_V4, 64'd0, 64'h0000_0000_FFFF_F000, 8'd20);
      send_address(ipac_pkg::FAM_V6, 64'd0, 64'd0, 8'd0);
      send_address(ipac_pkg::FAM_V6, 64'd0, 64'd1, 8'd128);
      send_address(ipac_pkg::FAM_V6, 64'd0, 64'h0000_FFFF_0000_0000, 8'd96);
      send_address(ipac_pkg::FAM_V6, 64'd0, 64'h0000_FFFF_C000_0201, 8'd200);
      send_address(ipac_pkg::FAM_V6, 64'd0, 64'h0000_0000_C000_0201, 8'd64);
      send_address(ipac_pkg::FAM_V6, 64'hFE80_0000_0000_0000, 64'd1, 8'd10);
      send_address(ipac_pkg::FAM_V6, 64'hFEC0_0000_0000_0000, 64'd1, 8'd65);
      send_address(ipac_pkg::FAM_V6, 64'hFD12_3456_0000_0000, 64'd0, 8'd7);
      send_address(ipac_pkg::FAM_V6, 64'h2001_0000_1234_5678, 64'h9ABC_DEF0_1234_5678, 8'd32);
      send_address(ipac_pkg::FAM_V6, 64'h2002_C000_0201_0000, 64'd0, 8'd48);
      send_address(ipac_pkg::FAM_V6, 64'h3FFE_0000_0000_0000, 64'd7, 8'd16);
      send_address(ipac_pkg::FAM_V6, 64'h2001_0DB8_0000_0000, 64'h0211_22FF_FE33_4455, 8'd127);
      send_address(ipac_pkg::FAM_V6, '1, '1, 8'd128);
      send_address(ipac_pkg::FAM_V6, 64'hFFFF_FFFF_F0F0_0000, 64'd0, 8'd255);
      stop_sending();
   endtask

   task automatic test_full_rate();
      run_random_phase(0, 0, RANDOM_ITEMS);
   endtask

   task automatic test_sender_gaps();
      run_random_phase(49, 0, RANDOM_ITEMS);
   endtask

   task automatic test_receiver_stalls();
      run_random_phase(0, 49, RANDOM_ITEMS);
   endtask

   task automatic test_both_idle();
      run_random_phase(12, 12, RANDOM_ITEMS);
   endtask

   task automatic test_backpressure();
      hold_pending = 1'b1;
      run_random_phase(0, 0, 40);
      stop_sending();
   endtask

   initial begin
      forever begin
         @(negedge clock);
         if (hold_pending) begin
            hold_pending = 1'b0;
            rsp_ready <= 1'b0;
            for (int n = 1; n < HOLD_CYCLES; n++) @(negedge clock);
         end else begin
            rsp_ready <= ($urandom_range(99) >= stall_pct);
         end
      end
   end

   task automatic compare_field(input string name, input logic [63:0] want,
                                input logic [63:0] got);
      if (want !== got) begin
         $display("%0t: %s expected %0h actual %0h", $realtime, name, want, got);
         mismatches++;
      end
   endtask

   always @(posedge clock) begin : check_rsp
      ipac_pkg::rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (predicted_classes.size() == 0) begin
            $display("%0t: beat with nothing expected, precedence actual %0d",
                     $realtime, rsp_precedence);
            mismatches++;
         end else begin
            want = predicted_classes.pop_front();
            compare_field("precedence", want.precedence, rsp_precedence);
            compare_field("is_private", want.is_private, rsp_is_private);
            compare_field("is_loopback", want.is_loopback, rsp_is_loopback);
            compare_field("is_link_local", want.is_link_local, rsp_is_link_local);
            compare_field("is_any", want.is_any, rsp_is_any);
            compare_field("ipv6_kind", want.ipv6_kind, rsp_ipv6_kind);
            compare_field("truncated_high", want.truncated_high, rsp_truncated_high);
            compare_field("truncated_low", want.truncated_low, rsp_truncated_low);
            compare_field("mask_bit_count", want.mask_bit_count, rsp_mask_bit_count);
            compare_field("word_hash", want.word_hash, rsp_word_hash);
         end
      end
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
         $display("tb_ip_address_classifier: done, errors");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      test_directed();
      test_full_rate();
      test_sender_gaps();
      test_receiver_stalls();
      test_both_idle();
      test_backpressure();
      stall_pct = 0;
      while (predicted_classes.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      if (mismatches == 0) begin
         $display("tb_ip_address_classifier: done, clean");
      end else begin
         $display("tb_ip_address_classifier: done, errors");
      end
      $finish;
   end

endmodule

`default_nettype wire

>>> files.f
src/ipac_pkg.sv
src/ipac_classify.sv
src/ip_address_classifier.sv
tb/sv/tb_ip_address_classifier.sv
